// ===== rtl/core/btps_pkg.sv =====
// Package of shared constants, codes and types for the banded traceback pointer store.
package btps_pkg;

  localparam int MAX_LEN     = 2048;
  localparam int PTR_NIBBLES = 262144;

  localparam int TABLE_DEPTH = 2 * MAX_LEN + 1;
  localparam int MEM_BYTES   = (PTR_NIBBLES + 1) / 2;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int LOC_W       = ($clog2(PTR_NIBBLES) + 2 > 21) ? $clog2(PTR_NIBBLES) + 2 : 21;
  localparam int CLR_N       = (MEM_BYTES > TABLE_DEPTH) ? MEM_BYTES : TABLE_DEPTH;
  localparam int CLR_W       = $clog2(CLR_N);

  localparam int LEN_W   = 12;
  localparam int COORD_W = 12;
  localparam int DIAG_W  = 12;
  localparam int BAND_W  = 12;
  localparam int INDEX_W = 19;
  localparam int NIB_W   = 4;
  localparam int OFF_W   = 14;
  localparam int TBL_W   = 2 * BAND_W + INDEX_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic REG_FIRST_LEN  = 1'b0;
  localparam logic REG_SECOND_LEN = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CALC,
    ST_MRD,
    ST_MOD,
    ST_LOAD,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/btps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module btps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/banded_traceback_pointer_store.sv =====
// Top level of the banded traceback pointer store: table, pointer memory and sequencer.
// A write or read item passes through the states ST_LOOK, ST_CALC, ST_MRD, ST_MOD and ST_OUT.
// A load item passes through ST_LOAD and ST_OUT; an item with an unused code goes straight to ST_OUT.
// The sequencer visits the diagonal table and then the pointer memory, one synchronous read
// each, and finishes one item before taking the next.
// After reset a clearing pass over max(MEM_BYTES, TABLE_DEPTH) addresses (131072 by default) sets
// every table entry to -1 and every pointer byte to zero; no item is taken during it.
module banded_traceback_pointer_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_command,
  input  logic [btps_pkg::COORD_W-1:0]     in_x_coord,
  input  logic [btps_pkg::COORD_W-1:0]     in_y_coord,
  input  logic [btps_pkg::NIB_W-1:0]       in_pointer_value,
  input  logic [btps_pkg::DIAG_W-1:0]      in_diag_number,
  input  logic signed [btps_pkg::BAND_W-1:0]  in_band_start,
  input  logic signed [btps_pkg::BAND_W-1:0]  in_band_end,
  input  logic signed [btps_pkg::INDEX_W-1:0] in_base_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [btps_pkg::NIB_W-1:0]       out_pointer_out,
  output logic                             out_in_range,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [btps_pkg::ADDR_W-1:0]      paddr,
  input  logic [btps_pkg::DATA_W-1:0]      pwdata,
  output logic [btps_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import btps_pkg::*;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0] first_len_r, second_len_r;
  logic [CLR_W-1:0] clr_r;

  logic [1:0]                cmd_r;
  logic [COORD_W-1:0]        x_r, y_r;
  logic [NIB_W-1:0]          ptr_r;
  logic [DIAG_W-1:0]         diag_r;
  logic signed [BAND_W-1:0]  bs_r, be_r;
  logic signed [INDEX_W-1:0] bi_r;

  logic                      dok_r;
  logic signed [OFF_W-1:0]   off_r;
  logic signed [LOC_W-1:0]   loc_r;
  logic                      hit_r;
  logic [NIB_W-1:0]          res_ptr_r, res_ptr_nxt;
  logic                      res_rng_r, res_rng_nxt;
  logic                      out_valid_r;
  logic [NIB_W-1:0]          out_ptr_r;
  logic                      out_rng_r;

  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [TBL_W-1:0]  tbl_wdata, tbl_rdata;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              out_load;

  logic                       clr_last, clr_mem, clr_tbl;
  logic [COORD_W:0]           sum_xy, diag_xy;
  logic                       dok_nxt;
  logic signed [OFF_W-1:0]    off_nxt;
  logic signed [BAND_W-1:0]   tbl_start, tbl_end;
  logic signed [INDEX_W-1:0]  tbl_index;
  logic                       in_band;
  logic signed [LOC_W-1:0]    loc_nxt;
  logic                       hit_nxt;
  logic                       cfg_write;

  btps_ram #(.WIDTH(TBL_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  btps_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ptr_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign clr_last = (clr_r == CLR_W'(CLR_N - 1));
  assign clr_mem  = ({1'b0, clr_r} < (CLR_W + 1)'(MEM_BYTES));
  assign clr_tbl  = ({1'b0, clr_r} < (CLR_W + 1)'(TABLE_DEPTH));

  assign sum_xy  = {1'b0, x_r} + {1'b0, y_r};
  assign diag_xy = sum_xy - (COORD_W + 1)'(1);
  assign dok_nxt = (sum_xy >= (COORD_W + 1)'(2))
                && (sum_xy <= ({1'b0, first_len_r} + {1'b0, second_len_r}))
                && ({{(32 - COORD_W - 1){1'b0}}, diag_xy} < 32'(TABLE_DEPTH));
  assign off_nxt = (diag_xy < {1'b0, second_len_r})
                 ? $signed({2'b00, x_r}) - OFF_W'(1)
                 : $signed({2'b00, second_len_r}) - $signed({2'b00, y_r});

  assign tbl_start = tbl_rdata[TBL_W-1 -: BAND_W];
  assign tbl_end   = tbl_rdata[INDEX_W +: BAND_W];
  assign tbl_index = tbl_rdata[INDEX_W-1:0];
  assign in_band   = (off_r >= OFF_W'(tbl_start)) && (off_r <= OFF_W'(tbl_end));
  assign loc_nxt   = LOC_W'(tbl_index) + LOC_W'(off_r) - LOC_W'(tbl_start);
  assign hit_nxt   = dok_r && in_band && !loc_nxt[LOC_W-1]
                  && (loc_nxt[LOC_W-2:0] < (LOC_W - 1)'(PTR_NIBBLES));

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_FIRST_LEN:  prdata = {{(DATA_W - LEN_W){1'b0}}, first_len_r};
      REG_SECOND_LEN: prdata = {{(DATA_W - LEN_W){1'b0}}, second_len_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_LOAD:            state_nxt = ST_LOAD;
            CMD_WRITE, CMD_READ: state_nxt = ST_LOOK;
            default:             state_nxt = ST_OUT;
          endcase
        end
      end
      ST_LOOK: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_MRD;
      ST_MRD:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_OUT;
      ST_LOAD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    tbl_we      = 1'b0;
    tbl_waddr   = TBL_AW'(diag_r);
    tbl_wdata   = {bs_r, be_r, bi_r};
    tbl_raddr   = TBL_AW'(diag_xy);
    mem_we      = 1'b0;
    mem_waddr   = loc_r[MEM_AW:1];
    mem_wdata   = loc_r[0] ? {mem_rdata[7:4], ptr_r} : {ptr_r, mem_rdata[3:0]};
    mem_raddr   = loc_r[MEM_AW:1];
    res_ptr_nxt = res_ptr_r;
    res_rng_nxt = res_rng_r;
    out_load    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        tbl_we    = clr_tbl;
        tbl_waddr = TBL_AW'(clr_r);
        tbl_wdata = '1;
        mem_we    = clr_mem;
        mem_waddr = MEM_AW'(clr_r);
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        res_ptr_nxt = '0;
        res_rng_nxt = 1'b0;
      end
      ST_MOD: begin
        mem_we      = hit_r && (cmd_r == CMD_WRITE);
        res_rng_nxt = hit_r;
        if (hit_r && (cmd_r == CMD_READ)) begin
          res_ptr_nxt = loc_r[0] ? mem_rdata[3:0] : mem_rdata[7:4];
        end
      end
      ST_LOAD: begin
        tbl_we = ({{(32 - DIAG_W){1'b0}}, diag_r} < 32'(TABLE_DEPTH));
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      first_len_r  <= LEN_W'(1);
      second_len_r <= LEN_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      if (cfg_write) begin
        unique case (paddr[2])
          REG_FIRST_LEN:  first_len_r  <= pwdata[LEN_W-1:0];
          REG_SECOND_LEN: second_len_r <= pwdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_command;
      x_r    <= in_x_coord;
      y_r    <= in_y_coord;
      ptr_r  <= in_pointer_value;
      diag_r <= in_diag_number;
      bs_r   <= in_band_start;
      be_r   <= in_band_end;
      bi_r   <= in_base_index;
    end
    if (state_r == ST_LOOK) begin
      dok_r <= dok_nxt;
      off_r <= off_nxt;
    end
    if (state_r == ST_CALC) begin
      loc_r <= loc_nxt;
      hit_r <= hit_nxt;
    end
    res_ptr_r <= res_ptr_nxt;
    res_rng_r <= res_rng_nxt;
    if (out_load) begin
      out_ptr_r <= res_ptr_r;
      out_rng_r <= res_rng_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pointer_out = out_ptr_r;
  assign out_in_range    = out_rng_r;

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("Result appeared without passing the output state.");

  a_mem_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_CLEAR) |-> (hit_r && cmd_r == CMD_WRITE))
    else $error("Pointer memory written without a write hit.");

  a_ptr_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pointer_out != '0) |-> out_in_range)
    else $error("Nonzero pointer returned for a cell out of range.");

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !clr_last) |=> (state_r == ST_CLEAR && !in_ready))
    else $error("Clearing pass ended early.");

endmodule
